// ===== src/ssbs_pkg.sv =====
package ssbs_pkg;

  localparam int KEY_W = 32;   // table word / search key
  localparam int IDX_W = 10;   // entry_index, match_index
  localparam int CNT_W = 11;   // entry_count

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // register byte offsets (paddr[2] selects the word)
  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } ssbs_state_t;

endpackage

// ===== src/ssbs_if.sv =====
interface ssbs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [ssbs_pkg::IDX_W-1:0]       entry_index;
  logic signed [ssbs_pkg::KEY_W-1:0] key_value;

  modport source (output valid, kind, entry_index, key_value, input ready);
  modport sink   (input valid, kind, entry_index, key_value, output ready);
endinterface

interface ssbs_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [ssbs_pkg::IDX_W-1:0] match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

// ===== src/ssbs_ram.sv =====
module ssbs_ram #(
  parameter int DEPTH = ssbs_pkg::TABLE_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [ssbs_pkg::KEY_W-1:0] wdata,
  input  logic [AW-1:0]                    raddr,
  output logic signed [ssbs_pkg::KEY_W-1:0] rdata
);

  logic signed [ssbs_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, one read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sorted_int_binary_search.sv =====
// Channel   Dir  Handshake     Payload
// in_chan   in   valid/ready   kind, entry_index[9:0], key_value[31:0] (signed)
// out_chan  out  valid/ready   found, match_index[9:0]
// APB cfg   in   psel/penable  reg 0 at 0x0: entry_count[10:0]
//
// A write item is written at its accept edge. Search item: the accept edge launches the
// first read, then the probes follow, at most floor(log2(count))+1 probes.
// A search with entry_count of zero loads its not-found result at the accept edge.
// Each probe is one registered read of the table RAM plus one compare.
// rst_n is synchronous, active low; it clears control state only, table words hold
// garbage until written. Input stalls while a search runs or a result waits unclaimed.
module sorted_int_binary_search #(
  parameter int TABLE_DEPTH = ssbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ssbs_in_if.sink     in_chan,
  ssbs_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = ssbs_pkg::CNT_W;
  localparam int IDX_W = ssbs_pkg::IDX_W;
  localparam int KEY_W = ssbs_pkg::KEY_W;

  ssbs_pkg::ssbs_state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        cnt_sat;
  // bisection window: [lo, hi) with hi exclusive
  logic [CNT_W-1:0]        lo_r, hi_r, mid_r;
  logic [CNT_W-1:0]        lo_nxt, hi_nxt, mid_nxt;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] rd_data;

  logic out_valid_r, out_valid_nxt;
  logic found_r;
  logic [IDX_W-1:0] match_idx_r;

  logic accept, is_search, start_search, zero_search;
  logic hit, less, done, finish;
  logic we;
  logic [AW-1:0] waddr, raddr;

  // ---------------- config port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == ssbs_pkg::REG_ENTRY_COUNT)) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ssbs_pkg::REG_ENTRY_COUNT) begin
      prdata = {{(32-CNT_W){1'b0}}, count_r};
    end
  end

  // count above depth saturates
  assign cnt_sat = CNT_W'((32'(count_r) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                            : 32'(count_r));

  // ---------------- handshake ----------------
  assign in_chan.ready = (state_r == ssbs_pkg::ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_search     = (in_chan.kind == ssbs_pkg::KIND_SEARCH);
  assign start_search  = accept && is_search && (cnt_sat != '0);
  assign zero_search   = accept && is_search && (cnt_sat == '0);

  // ---------------- table RAM ----------------
  assign we    = accept && (in_chan.kind == ssbs_pkg::KIND_WRITE)
                 && (32'(in_chan.entry_index) < 32'(TABLE_DEPTH));
  assign waddr = AW'(32'(in_chan.entry_index));
  assign raddr = AW'(32'(mid_nxt));

  ssbs_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_chan.key_value),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // ---------------- probe compare and window update ----------------
  // rd_data holds table[mid_r] during ST_PROBE
  assign hit  = (rd_data == key_r);
  assign less = (rd_data < key_r);

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (less) begin
      lo_nxt = mid_r + CNT_W'(1);
    end else begin
      hi_nxt = mid_r;
    end
  end

  assign done   = hit || (lo_nxt >= hi_nxt);
  assign finish = (state_r == ssbs_pkg::ST_PROBE) && done;

  // next read address: first midpoint at launch, else midpoint of new window
  always_comb begin
    if (state_r == ssbs_pkg::ST_IDLE) begin
      mid_nxt = (cnt_sat - CNT_W'(1)) >> 1;
    end else begin
      mid_nxt = lo_nxt + ((hi_nxt - CNT_W'(1) - lo_nxt) >> 1);
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssbs_pkg::ST_IDLE: begin
        if (start_search) state_nxt = ssbs_pkg::ST_PROBE;
      end
      ssbs_pkg::ST_PROBE: begin
        if (done) state_nxt = ssbs_pkg::ST_IDLE;
      end
      default: state_nxt = ssbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish || zero_search) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssbs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    if (start_search) begin
      lo_r  <= '0;
      hi_r  <= cnt_sat;
      key_r <= in_chan.key_value;
      mid_r <= mid_nxt;
    end else if ((state_r == ssbs_pkg::ST_PROBE) && !done) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= mid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (zero_search) begin
      found_r     <= 1'b0;
      match_idx_r <= '0;
    end else if (finish) begin
      found_r     <= hit;
      match_idx_r <= hit ? mid_r[IDX_W-1:0] : '0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = found_r;
  assign out_chan.match_index = match_idx_r;

endmodule

// ===== bench/tb.sv =====
module tb;

  localparam int          KEY_W         = ssbs_pkg::KEY_W;
  localparam int          IDX_W         = ssbs_pkg::IDX_W;
  localparam int          CNT_W         = ssbs_pkg::CNT_W;
  localparam int          DEPTH         = ssbs_pkg::TABLE_DEPTH_DEF;
  localparam int          RANDOM_ITEMS  = 300;
  localparam int          SETTLE_CYCLES = 20;   // one write or one full 11-probe search
  localparam int          HOLD_CYCLES   = 150;
  localparam longint      FILL_STEP     = 4198404;   // spreads fill words over the key range
  localparam logic [2:0]  ADDR_ENTRY_COUNT = {ssbs_pkg::REG_ENTRY_COUNT, 2'b00};
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  // one search answer as the block should deliver it
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } lookup_t;

  logic clk = 1'b0;
  logic rst_n;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ssbs_in_if  in_if ();
  ssbs_out_if out_if ();

  sorted_int_binary_search i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // bench copy of the block state
  logic signed [KEY_W-1:0] word_store [DEPTH];
  logic [CNT_W-1:0]        count_reg = '0;
  lookup_t                 lookup_due [$];   // answers owed, oldest first
  bit                      fill_done [DEPTH];  // entry holds its fill word

  int unsigned err_count   = 0;
  int unsigned mixed_items = 0;
  bit          feed_gaps   = 1'b1;   // sender idles between items
  bit          drain_gaps  = 1'b1;   // receiver idles between items
  logic        hold_active;
  int unsigned sink_wait;
  event        start_hold;

  task automatic report(input string what);
    err_count++;
    $display("tb: mismatch: %s", what);
  endtask

  // Bisect the first count entries; first equal probe wins, so duplicates
  // resolve by probe order. Count saturates at the table depth.
  function automatic lookup_t bisect_lookup(input logic signed [KEY_W-1:0] key);
    int      lo;
    int      hi;
    int      mid;
    lookup_t r;
    r  = '{found: 1'b0, idx: '0};
    lo = 0;
    hi = ((count_reg > DEPTH) ? DEPTH : int'(count_reg)) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (word_store[mid] == key) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(mid);
        return r;
      end else if (word_store[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  // Ascending word for an entry of the large table, from the key minimum up.
  function automatic logic signed [KEY_W-1:0] fill_word(input int i);
    return KEY_W'(-64'sd2147483648 + longint'(i) * FILL_STEP);
  endfunction

  // Offer one item and wait for the handshake. Called at a rising edge;
  // valid stays high when the next item follows with no gap.
  task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic signed [KEY_W-1:0] key);
    int unsigned gap_n;
    gap_n = feed_gaps ? $urandom_range(9, 0) : 0;
    if (gap_n != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap_n) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= kind;
    in_if.entry_index <= idx;
    in_if.key_value   <= key;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (kind == ssbs_pkg::KIND_SEARCH) begin
      lookup_due.push_back(bisect_lookup(key));
    end else begin
      word_store[idx] = key;
    end
  endtask

  // Search the whole table with only the entries on the key's probe path
  // written: each one missing its fill word gets it first.
  task automatic search_on_path(input logic signed [KEY_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = DEPTH - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (!fill_done[mid]) begin
        send_item(ssbs_pkg::KIND_WRITE, IDX_W'(mid), fill_word(mid));
        fill_done[mid] = 1'b1;
      end
      if (fill_word(mid) == key) break;
      else if (fill_word(mid) < key) lo = mid + 1;
      else hi = mid - 1;
    end
    send_item(ssbs_pkg::KIND_SEARCH, IDX_W'($urandom), key);
  endtask

  // Quiet the input, wait for every owed answer, then let a trailing
  // write or search finish before touching the register.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (lookup_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of entry_count, then read it back.
  task automatic set_entry_count(input int unsigned n);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ENTRY_COUNT;
    pwdata  <= n;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    count_reg = n[CNT_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {{(32 - CNT_W){1'b0}}, count_reg}) begin
      report($sformatf("entry_count reads %0h, want %0h", rd, count_reg));
    end
  endtask

  // Ascending run into entries 0..n-1; some steps are zero to make duplicates.
  task automatic load_sorted(input int unsigned n, input longint start,
                             input int unsigned max_step);
    longint v;
    v = start;
    for (int unsigned i = 0; i < n; i++) begin
      send_item(ssbs_pkg::KIND_WRITE, IDX_W'(i), KEY_W'(v));
      if ($urandom_range(7, 0) != 0) v += $urandom_range(max_step, 1);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
    end
  endtask

  // Mostly keys that sit in the searched range, some near misses, some noise.
  function automatic logic signed [KEY_W-1:0] pick_key(input int unsigned n);
    int unsigned             r;
    logic signed [KEY_W-1:0] k;
    r = $urandom_range(99, 0);
    if (n != 0 && r < 60) begin
      k = word_store[$urandom_range(n - 1, 0)];
    end else if (n != 0 && r < 80) begin
      k = word_store[$urandom_range(n - 1, 0)];
      if (r[0]) k = k + 32'sd1;
      else k = k - 32'sd1;
    end else if (r < 95) begin
      k = $urandom;
    end else begin
      k = r[0] ? KEY_MAX : KEY_MIN;
    end
    return k;
  endfunction

  // Result side: per-item stall drawn after each handshake, forced low while
  // a hold is running. Values are sampled as they stood before the edge.
  always @(posedge clk) begin : result_sink
    int unsigned gap_n;
    lookup_t     want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      sink_wait    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (lookup_due.size() == 0) begin
          report("search answer with no search outstanding");
        end else begin
          want = lookup_due.pop_front();
          if (out_if.found !== want.found) begin
            report($sformatf("found %b, want %b", out_if.found, want.found));
          end
          if (out_if.match_index !== want.idx) begin
            report($sformatf("match_index %0d, want %0d", out_if.match_index, want.idx));
          end
        end
        gap_n = drain_gaps ? $urandom_range(9, 0) : 0;
      end else begin
        gap_n = (sink_wait > 0) ? sink_wait - 1 : 0;
      end
      sink_wait    <= gap_n;
      out_if.ready <= (gap_n == 0) && !hold_active;
    end
  end

  // Long receiver hold-off: the result register fills and input backs up.
  initial begin : backpressure
    hold_active = 1'b0;
    forever begin
      @(start_hold);
      @(posedge clk);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  task automatic test_directed();
    // count is zero after reset: always not found
    send_item(ssbs_pkg::KIND_SEARCH, '1, 32'sd0);
    // seven sorted entries with a duplicated pair, plus the top slot
    send_item(ssbs_pkg::KIND_WRITE, 10'd0, KEY_MIN);
    send_item(ssbs_pkg::KIND_WRITE, 10'd1, -32'sd5);
    send_item(ssbs_pkg::KIND_WRITE, 10'd2, -32'sd1);
    send_item(ssbs_pkg::KIND_WRITE, 10'd3, 32'sd0);
    send_item(ssbs_pkg::KIND_WRITE, 10'd4, 32'sd7);
    send_item(ssbs_pkg::KIND_WRITE, 10'd5, 32'sd7);
    send_item(ssbs_pkg::KIND_WRITE, 10'd6, KEY_MAX);
    send_item(ssbs_pkg::KIND_WRITE, 10'd1023, -32'sd1);
    wait_drained();
    set_entry_count(7);
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, KEY_MIN);
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, KEY_MAX);
    send_item(ssbs_pkg::KIND_SEARCH, '1, 32'sd7);      // duplicate: probe order picks
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, 32'sd0);
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, -32'sd1);
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, -32'sd6);  // miss between entries
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, 32'sd8);
    // single-entry table
    wait_drained();
    set_entry_count(1);
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, KEY_MIN);
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, 32'sd0);
    // break the order and search through it anyway
    wait_drained();
    set_entry_count(7);
    send_item(ssbs_pkg::KIND_WRITE, 10'd3, -32'sd100);
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, -32'sd100);
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, 32'sd0);
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, -32'sd5);
    wait_drained();
    set_entry_count(0);
    send_item(ssbs_pkg::KIND_SEARCH, 10'd0, KEY_MAX);
  endtask

  // Count at and above the depth: the deepest probe paths, including the
  // match at the top index and at the bottom entry, and a miss off the top of the table.
  task automatic test_full_table();
    int unsigned             t;
    logic signed [KEY_W-1:0] k;
    wait_drained();
    set_entry_count(DEPTH);
    search_on_path(fill_word(DEPTH - 1));
    search_on_path(fill_word(0));
    search_on_path(fill_word(DEPTH / 2 - 1));
    search_on_path(KEY_MAX);
    search_on_path(KEY_MIN);
    for (int i = 0; i < 20; i++) begin
      t = $urandom_range(DEPTH - 1, 0);
      k = fill_word(int'(t));
      case ($urandom_range(2, 0))
        0: k = k + 32'sd1;
        1: k = k - 32'sd1;
        default: ;
      endcase
      search_on_path(k);
    end
    // a count past the depth searches the whole table
    wait_drained();
    set_entry_count((1 << CNT_W) - 1);
    search_on_path(fill_word(DEPTH - 1));
    search_on_path(fill_word(int'($urandom_range(DEPTH - 1, 0))));
    search_on_path(KEY_MAX);
  endtask

  // Phases: pick a count, load a fresh sorted run, throw in stray writes,
  // set the register while idle, then a burst of searches mixed with stray writes.
  task automatic test_random_phases();
    int unsigned             n;
    int unsigned             r;
    int unsigned             searches;
    int unsigned             phase_no;
    logic signed [KEY_W-1:0] base;
    phase_no = 0;
    while (mixed_items < RANDOM_ITEMS) begin
      wait_drained();
      feed_gaps  = ($urandom_range(3, 0) != 0);
      drain_gaps = ($urandom_range(3, 0) != 0);
      r = $urandom_range(99, 0);
      if (r < 10) n = 0;
      else n = $urandom_range(48, 1);
      if (n != 0) begin
        base = $urandom;
        load_sorted(n, base, r[0] ? 3 : 32'h0100_0000);
        mixed_items += n;
      end
      repeat ($urandom_range(3, 0)) begin
        send_item(ssbs_pkg::KIND_WRITE, IDX_W'($urandom), $urandom);
        mixed_items++;
      end
      wait_drained();
      set_entry_count(n);
      if (phase_no % 8 == 3) begin
        // keep offering items back to back while the receiver holds off
        feed_gaps = 1'b0;
        -> start_hold;
      end
      searches = $urandom_range(16, 6);
      repeat (searches) begin
        if ($urandom_range(9, 0) == 0) begin
          send_item(ssbs_pkg::KIND_WRITE, IDX_W'($urandom), $urandom);
        end else begin
          send_item(ssbs_pkg::KIND_SEARCH, IDX_W'($urandom), pick_key(n));
        end
        mixed_items++;
      end
      phase_no++;
    end
  endtask

  initial begin : run
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.kind        <= ssbs_pkg::KIND_WRITE;
    in_if.entry_index <= '0;
    in_if.key_value   <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random_phases();
    wait_drained();
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // generous bound on a correct run
  initial begin : watchdog
    #5000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
src/ssbs_pkg.sv
src/ssbs_if.sv
src/ssbs_ram.sv
src/sorted_int_binary_search.sv
bench/tb.sv
